// ===== rtl/core/pattern_coordinate_generator_macros.svh =====
// Assertion macros shared by the pattern coordinate generator RTL.
`ifndef PATTERN_COORDINATE_GENERATOR_MACROS_SVH
`define PATTERN_COORDINATE_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define PCG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, also during reset.
`define PCG_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCG_ASSERT(lbl, prop, msg)
`define PCG_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/pcg_pkg.sv =====
// Shared types, constants and helpers of the pattern coordinate generator.
package pcg_pkg;

	// Defaults of the top-level parameters.
	localparam int MAX_SIDE_DEF  = 4096;
	localparam int FRAC_BITS_DEF = 16;

	// Field widths.
	localparam int SIDE_W     = 13;
	localparam int POS_W      = 12;
	localparam int BOUND_W    = 8;
	localparam int MAG_W      = POS_W + BOUND_W;
	localparam int OUT_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;

	// Coordinate saturation limits.
	localparam int SAT_HI = 8388607;
	localparam int SAT_LO = -8388608;

	// Radius datapath: radicand is 49*(x*x+y*y), root is its floor square root.
	localparam int RAD_W      = 54;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int PROD_W     = 55;
	localparam int DIV5_SHIFT = 30;
	localparam int DIV5_MUL   = ((1 << DIV5_SHIFT) + 4) / 5;

	localparam int QUEUE_DEPTH = 4;

	// Register indexes of the configuration port.
	typedef logic [CFG_IDX_W-1:0] reg_idx_t;
	localparam reg_idx_t REG_IMAGE_WIDTH  = 3'd0;
	localparam reg_idx_t REG_IMAGE_HEIGHT = 3'd1;
	localparam reg_idx_t REG_X_MINIMUM    = 3'd2;
	localparam reg_idx_t REG_X_MAXIMUM    = 3'd3;
	localparam reg_idx_t REG_Y_MINIMUM    = 3'd4;
	localparam reg_idx_t REG_Y_MAXIMUM    = 3'd5;

	typedef struct packed {
		logic        [SIDE_W-1:0]  image_width;
		logic        [SIDE_W-1:0]  image_height;
		logic signed [BOUND_W-1:0] x_minimum;
		logic signed [BOUND_W-1:0] x_maximum;
		logic signed [BOUND_W-1:0] y_minimum;
		logic signed [BOUND_W-1:0] y_maximum;
	} cfg_t;

	typedef struct packed {
		logic [POS_W-1:0] column;
		logic [POS_W-1:0] row;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] coord_x;
		logic signed [OUT_W-1:0] coord_y;
		logic        [OUT_W-1:0] radius;
		logic        [OUT_W-1:0] pixel_index;
		logic                    out_of_range;
	} out_item_t;

	// Classified request as it waits in the queue.
	typedef struct packed {
		logic [MAG_W-1:0] mag_x;
		logic             neg_x;
		logic [MAG_W-1:0] mag_y;
		logic             neg_y;
		logic [OUT_W-1:0] pixel_index;
		logic             out_of_range;
	} q_item_t;

	// Data that rides along with the radius computation.
	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic        [OUT_W-1:0] pixel_index;
		logic                    out_of_range;
	} rad_side_t;

	// Zero counts as one; values above the cap count as the cap.
	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] r,
			input logic [SIDE_W-1:0] cap);
		logic [SIDE_W-1:0] s;
		s = r;
		if (r == '0) s = SIDE_W'(1);
		if (r > cap) s = cap;
		return s;
	endfunction

endpackage

// ===== rtl/core/pattern_coordinate_generator.sv =====
// Top level of the pattern coordinate generator.
//
// Each request on the input channel carries a pixel column and row; each result carries
// the x and y coordinates, the scaled radius, the linear pixel index and a range flag.
// Both channels use valid and stall: a transfer happens on a rising edge with valid
// high and stall low. Configuration is a write-only register port (cfg_write,
// cfg_index, cfg_data) that must be used only while no request is in flight.
// Throughput is one request per cycle while out_stall is low. From acceptance to the
// result showing on out_valid, a request passes the front-end register, the queue,
// the divider stages for the quotient bits, four arithmetic stages, 27 square-root
// stages and two stages for the final scaling.
// A four-entry queue separates the front end from the back-end pipeline, so input
// requests keep flowing until it fills. When out_stall and out_valid are both high the
// held result stays unchanged and the back-end pipeline freezes; the front end stalls
// once the queue is full. Reset empties pipeline and queue and loads register defaults.
module pattern_coordinate_generator import pcg_pkg::*; #(
	parameter int MAX_SIDE      = MAX_SIDE_DEF,
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_item_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_item_t             out_data
);

	cfg_t    cfg_q;
	logic    push, q_full, q_empty, pop;
	q_item_t push_data, q_head;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width  <= SIDE_W'(256);
			cfg_q.image_height <= SIDE_W'(256);
			cfg_q.x_minimum    <= -8'sd1;
			cfg_q.x_maximum    <= 8'sd1;
			cfg_q.y_minimum    <= -8'sd1;
			cfg_q.y_maximum    <= 8'sd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data;
				REG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data;
				REG_X_MINIMUM:    cfg_q.x_minimum    <= cfg_data[BOUND_W-1:0];
				REG_X_MAXIMUM:    cfg_q.x_maximum    <= cfg_data[BOUND_W-1:0];
				REG_Y_MINIMUM:    cfg_q.y_minimum    <= cfg_data[BOUND_W-1:0];
				REG_Y_MAXIMUM:    cfg_q.y_maximum    <= cfg_data[BOUND_W-1:0];
				default: ;
			endcase
		end
	end

	pcg_front #(.MAX_SIDE(MAX_SIDE)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	pcg_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	pcg_back #(.MAX_SIDE(MAX_SIDE), .FRACTION_BITS(FRACTION_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_data    (q_head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/core/pcg_front.sv =====
// Front end: accepts pixel positions and classifies them into queue requests.
module pcg_front import pcg_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	input  cfg_t     cfg,
	input  logic     q_full,
	output logic     push,
	output q_item_t  push_data
);

	localparam int SIDE_CAP = (MAX_SIDE < 8191) ? MAX_SIDE : 8191;
	localparam logic [SIDE_W-1:0] CAP = SIDE_W'(SIDE_CAP);

	logic [SIDE_W-1:0]      side_w, side_h;
	logic signed [BOUND_W:0] span_x, span_y;
	logic [BOUND_W-1:0]     abs_x, abs_y;
	logic [OUT_W-1:0]       pix_full;
	logic                   accept;
	q_item_t                item_c;
	q_item_t                item_s1;
	logic                   vld_s1;

	// Span magnitudes, products, pixel index and range flag.
	always_comb begin
		side_w = clamp_side(cfg.image_width, CAP);
		side_h = clamp_side(cfg.image_height, CAP);
		span_x = (BOUND_W+1)'(cfg.x_maximum) - (BOUND_W+1)'(cfg.x_minimum);
		span_y = (BOUND_W+1)'(cfg.y_maximum) - (BOUND_W+1)'(cfg.y_minimum);
		abs_x  = span_x[BOUND_W] ? BOUND_W'(-span_x) : span_x[BOUND_W-1:0];
		abs_y  = span_y[BOUND_W] ? BOUND_W'(-span_y) : span_y[BOUND_W-1:0];
		pix_full = OUT_W'(in_data.column) + OUT_W'(in_data.row) * OUT_W'(side_w);
		item_c.mag_x = MAG_W'(in_data.column) * MAG_W'(abs_x);
		item_c.neg_x = span_x[BOUND_W];
		item_c.mag_y = MAG_W'(in_data.row) * MAG_W'(abs_y);
		item_c.neg_y = span_y[BOUND_W];
		item_c.pixel_index = pix_full;
		item_c.out_of_range = (SIDE_W'(in_data.column) >= side_w) ||
			(SIDE_W'(in_data.row) >= side_h);
	end

	// Hold the request while the queue is full.
	assign in_stall  = vld_s1 && q_full;
	assign accept    = in_valid && !in_stall;
	assign push      = vld_s1 && !q_full;
	assign push_data = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_c;
		end
	end

endmodule

// ===== rtl/core/pcg_queue.sv =====
// Short request queue between the front end and the back end.
`include "pattern_coordinate_generator_macros.svh"
module pcg_queue import pcg_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t push_data,
	output logic    full,
	input  logic    pop,
	output logic    empty,
	output q_item_t head
);

	localparam int DEPTH = QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	q_item_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	`PCG_ASSERT(a_cnt_bound, (cnt_q <= CNT_W'(DEPTH)), "queue count above depth")
	`PCG_ASSERT(a_pop_nonempty, (pop |-> cnt_q != '0), "pop from an empty queue")
	`PCG_ASSERT(a_push_counts, ((push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1), "push lost")

endmodule

// ===== rtl/core/pcg_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module pcg_div #(
	parameter int DW = 36,
	parameter int VW = 13,
	parameter int TW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_vld,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	input  logic [TW-1:0] in_side,
	output logic          out_vld,
	output logic [DW-1:0] quotient,
	output logic [TW-1:0] out_side
);

	logic [VW-1:0] rem_s  [1:DW];
	logic [DW-1:0] acc_s  [1:DW];
	logic [TW-1:0] side_s [1:DW];
	logic          vld_s  [1:DW];

	for (genvar k = 0; k < DW; k++) begin : g_stage
		logic [VW-1:0] cur_rem;
		logic [DW-1:0] cur_acc;
		logic [TW-1:0] cur_side;
		logic          cur_vld;
		logic [VW:0]   pr;
		logic          ge;

		if (k == 0) begin : g_first
			assign cur_rem  = '0;
			assign cur_acc  = dividend;
			assign cur_side = in_side;
			assign cur_vld  = in_vld;
		end else begin : g_next
			assign cur_rem  = rem_s[k];
			assign cur_acc  = acc_s[k];
			assign cur_side = side_s[k];
			assign cur_vld  = vld_s[k];
		end

		// Bring down one dividend bit and try to subtract the divisor.
		assign pr = {cur_rem, cur_acc[DW-1]};
		assign ge = (pr >= {1'b0, divisor});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? VW'(pr - {1'b0, divisor}) : VW'(pr);
				acc_s[k+1]  <= {cur_acc[DW-2:0], ge};
				side_s[k+1] <= cur_side;
			end
		end
	end

	assign out_vld  = vld_s[DW];
	assign quotient = acc_s[DW];
	assign out_side = side_s[DW];

endmodule

// ===== rtl/core/pcg_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage.
module pcg_sqrt #(
	parameter int SW = 54,
	parameter int TW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_vld,
	input  logic [SW-1:0]   radicand,
	input  logic [TW-1:0]   in_side,
	output logic            out_vld,
	output logic [SW/2-1:0] root,
	output logic [TW-1:0]   out_side
);

	localparam int QW = SW / 2;
	localparam int RW = QW + 3;

	logic [RW-1:0] rem_s  [1:QW];
	logic [QW-1:0] root_s [1:QW];
	logic [SW-1:0] acc_s  [1:QW];
	logic [TW-1:0] side_s [1:QW];
	logic          vld_s  [1:QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [RW-1:0] cur_rem;
		logic [QW-1:0] cur_root;
		logic [SW-1:0] cur_acc;
		logic [TW-1:0] cur_side;
		logic          cur_vld;
		logic [RW-1:0] pr, trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign cur_rem  = '0;
			assign cur_root = '0;
			assign cur_acc  = radicand;
			assign cur_side = in_side;
			assign cur_vld  = in_vld;
		end else begin : g_next
			assign cur_rem  = rem_s[k];
			assign cur_root = root_s[k];
			assign cur_acc  = acc_s[k];
			assign cur_side = side_s[k];
			assign cur_vld  = vld_s[k];
		end

		// Bring down two radicand bits and test the next root bit.
		assign pr    = {cur_rem[RW-3:0], cur_acc[SW-1:SW-2]};
		assign trial = RW'({cur_root, 2'b01});
		assign ge    = (pr >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? pr - trial : pr;
				root_s[k+1] <= {cur_root[QW-2:0], ge};
				acc_s[k+1]  <= {cur_acc[SW-3:0], 2'b00};
				side_s[k+1] <= cur_side;
			end
		end
	end

	assign out_vld  = vld_s[QW];
	assign root     = root_s[QW];
	assign out_side = side_s[QW];

endmodule

// ===== rtl/core/pcg_back.sv =====
// Back end: divides, offsets, saturates and computes the radius of each request.
`include "pattern_coordinate_generator_macros.svh"
module pcg_back import pcg_pkg::*; #(
	parameter int MAX_SIDE      = MAX_SIDE_DEF,
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_empty,
	input  q_item_t   q_data,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	localparam int DW   = MAG_W + FRACTION_BITS;
	localparam int CW   = DW + 2;
	localparam int XT_W = OUT_W + 2;
	localparam int SIDE_CAP = (MAX_SIDE < 8191) ? MAX_SIDE : 8191;
	localparam logic [SIDE_W-1:0] CAP = SIDE_W'(SIDE_CAP);
	localparam logic signed [CW-1:0] HI_C = CW'(SAT_HI);
	localparam logic signed [CW-1:0] LO_C = CW'(SAT_LO);
	localparam logic [OUT_W:0] RAD_MAX = {1'b0, {OUT_W{1'b1}}};

	function automatic logic signed [OUT_W-1:0] sat_coord(input logic signed [CW-1:0] v);
		logic signed [OUT_W-1:0] r;
		r = OUT_W'(v);
		if (v > HI_C) r = OUT_W'(HI_C);
		if (v < LO_C) r = OUT_W'(LO_C);
		return r;
	endfunction

	logic                adv;
	logic [SIDE_W-1:0]   side_w, side_h;
	logic                dvx_vld, dvy_vld;
	logic [DW-1:0]       qx, qy;
	logic [XT_W-1:0]     sx;
	logic [0:0]          sy;
	logic signed [CW-1:0] ux, uy, vx, vy;
	logic [OUT_W-1:0]    ax, ay;

	logic                    vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [OUT_W-1:0] x_s1, y_s1;
	logic [OUT_W-1:0]        pix_s1;
	logic                    flag_s1;
	logic [2*OUT_W-1:0]      sqx_s2, sqy_s2;
	rad_side_t               side_s2, side_s3, side_s4, side_s5;
	logic [2*OUT_W-1:0]      sum_s3;
	logic [RAD_W-1:0]        rad_s4;
	logic                    sq_vld;
	logic [ROOT_W-1:0]       sq_root;
	rad_side_t               sq_side;
	logic [PROD_W-1:0]       prod_s5;
	logic [OUT_W:0]          rad_c;
	logic                    out_vld_q;
	out_item_t               out_q;

	// The whole pipeline moves whenever the output register can take a result.
	assign adv = !out_vld_q || !out_stall;
	assign pop = adv && !q_empty;

	assign side_w = clamp_side(cfg.image_width, CAP);
	assign side_h = clamp_side(cfg.image_height, CAP);

	// Scaled span product divided by the grid size.
	pcg_div #(.DW(DW), .VW(SIDE_W), .TW(XT_W)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (pop),
		.dividend ({q_data.mag_x, {FRACTION_BITS{1'b0}}}),
		.divisor  (side_w),
		.in_side  ({q_data.neg_x, q_data.pixel_index, q_data.out_of_range}),
		.out_vld  (dvx_vld),
		.quotient (qx),
		.out_side (sx)
	);

	pcg_div #(.DW(DW), .VW(SIDE_W), .TW(1)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (pop),
		.dividend ({q_data.mag_y, {FRACTION_BITS{1'b0}}}),
		.divisor  (side_h),
		.in_side  (q_data.neg_y),
		.out_vld  (dvy_vld),
		.quotient (qy),
		.out_side (sy)
	);

	// Apply the sign of the span and add the scaled minimum.
	always_comb begin
		ux = $signed({2'b00, qx});
		uy = $signed({2'b00, qy});
		vx = (sx[XT_W-1] ? -ux : ux) + (CW'(cfg.x_minimum) <<< FRACTION_BITS);
		vy = (sy[0] ? -uy : uy) + (CW'(cfg.y_minimum) <<< FRACTION_BITS);
	end

	// Magnitudes for squaring.
	assign ax = x_s1[OUT_W-1] ? OUT_W'(-x_s1) : OUT_W'(x_s1);
	assign ay = y_s1[OUT_W-1] ? OUT_W'(-y_s1) : OUT_W'(y_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= dvx_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= sq_vld;
		end
	end

	// Saturate, square, sum and scale by 49 ahead of the root.
	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= sat_coord(vx);
			y_s1    <= sat_coord(vy);
			pix_s1  <= sx[OUT_W:1];
			flag_s1 <= sx[0];

			sqx_s2              <= (2*OUT_W)'(ax) * (2*OUT_W)'(ay == ay ? ax : ax);
			sqy_s2              <= (2*OUT_W)'(ay) * (2*OUT_W)'(ay);
			side_s2.x           <= x_s1;
			side_s2.y           <= y_s1;
			side_s2.pixel_index <= pix_s1;
			side_s2.out_of_range <= flag_s1;

			sum_s3  <= sqx_s2 + sqy_s2;
			side_s3 <= side_s2;

			rad_s4  <= (RAD_W'(sum_s3) << 5) + (RAD_W'(sum_s3) << 4) + RAD_W'(sum_s3);
			side_s4 <= side_s3;

			prod_s5 <= PROD_W'(sq_root) * PROD_W'(DIV5_MUL);
			side_s5 <= sq_side;
		end
	end

	pcg_sqrt #(.SW(RAD_W), .TW($bits(rad_side_t))) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (vld_s4),
		.radicand (rad_s4),
		.in_side  (side_s4),
		.out_vld  (sq_vld),
		.root     (sq_root),
		.out_side (sq_side)
	);

	// Divide the root by five through the reciprocal and clip to the field.
	always_comb begin
		rad_c = (OUT_W+1)'(prod_s5 >> DIV5_SHIFT);
		if (rad_c > RAD_MAX) rad_c = RAD_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.coord_x      <= side_s5.x;
			out_q.coord_y      <= side_s5.y;
			out_q.radius       <= rad_c[OUT_W-1:0];
			out_q.pixel_index  <= side_s5.pixel_index;
			out_q.out_of_range <= side_s5.out_of_range;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	`PCG_ASSERT_ALWAYS(a_div_lockstep, (dvx_vld == dvy_vld), "x and y dividers out of step")

endmodule
